// File: src/rwpe_pkg.sv
// ----------------------------------------------------------------------------
// rwpe_pkg
// shared types and constants of the wave pcm extractor: chunk ids, parse
// phases, error codes, register indexes and the parser state record
// ----------------------------------------------------------------------------
package rwpe_pkg;

    // chunk ids as they read little-endian from the stream
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] RESET_RATE     = 32'd44100;
    localparam logic [31:0] RESET_MAX_SIZE = 32'h0200_0000;
    localparam logic [15:0] NEED_BITS      = 16'd16;
    localparam logic [15:0] NEED_CHANNELS  = 16'd1;
    localparam logic [15:0] FORMAT_PCM     = 16'd1;
    localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;

    // parse phases
    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_HALT = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
    localparam logic [2:0] ERR_TOO_BIG    = 3'd2;
    localparam logic [2:0] ERR_RATE       = 3'd3;
    localparam logic [2:0] ERR_CHANNELS   = 3'd4;
    localparam logic [2:0] ERR_BITS       = 3'd5;
    localparam logic [2:0] ERR_COMPRESSED = 3'd6;
    localparam logic [2:0] ERR_SHORT_FMT  = 3'd7;

    // result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RIFF_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  position;
        logic [31:0] chunk_id_word;
        logic [31:0] chunk_size_word;
        logic [31:0] bytes_left;
        logic [15:0] format_word;
        logic [15:0] channels_word;
        logic [31:0] rate_word;
        logic [15:0] bits_word;
        logic        fmt_seen;
        logic [7:0]  low_byte;
    } t_state;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               kind;
        logic [2:0]         error_code;
        logic               last;
    } t_result;

endpackage

// File: src/rwpe_byte_if.sv
// ----------------------------------------------------------------------------
// rwpe_byte_if
// byte stream channel into the extractor
// ----------------------------------------------------------------------------
interface rwpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: src/rwpe_result_if.sv
// ----------------------------------------------------------------------------
// rwpe_result_if
// sample and error result channel out of the extractor
// ----------------------------------------------------------------------------
interface rwpe_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               kind;
    logic [2:0]         error_code;
    logic               last;

    modport source (output valid, output sample, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input sample, input kind, input error_code,
                    input last, output ready);
endinterface

// File: src/rwpe_cfg_if.sv
// ----------------------------------------------------------------------------
// rwpe_cfg_if
// register write channel of the extractor
// ----------------------------------------------------------------------------
interface rwpe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rwpe_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/riff_wave_pcm_extractor.sv
// ----------------------------------------------------------------------------
// riff_wave_pcm_extractor
// walks a wave file byte stream, checks the riff header and the fmt chunk,
// and emits the data chunk as signed 16-bit mono pcm samples
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      carries
//  -------   ---   ------------   -----------------------------------------
//  i_in      in    valid/ready    data_byte, one file byte per request
//  o_out     out   valid/ready    sample, kind, error_code, last
//  i_cfg     in    valid/ready    index, data (0 expected_rate, 1 max size)
//
//  one byte is taken per cycle; the parser state register updates on the
//  accepting edge and a sample or error lands in the output register there.
//  i_in.ready drops only while a result sits in the output register and
//  o_out.ready is low, so the output register alone sets the stall.
//  synchronous active-low reset returns to the riff header phase with
//  expected_rate 44100 and max_riff_size 1 << 25; the configuration
//  port is always ready.
//
module riff_wave_pcm_extractor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rwpe_byte_if.sink     i_in,
    rwpe_result_if.source o_out,
    rwpe_cfg_if.sink      i_cfg
);

    // configuration registers
    logic [31:0] r_expected_rate;
    logic [31:0] r_max_riff_size;

    // parser state
    rwpe_pkg::t_state  r_state;
    rwpe_pkg::t_state  n_state;

    // output register
    logic              r_out_valid;
    rwpe_pkg::t_result r_out;

    logic              res_valid;
    rwpe_pkg::t_result res;
    logic              in_acc;

    // a new byte fits whenever the output register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    rwpe_step u_step (
        .i_state         (r_state),
        .i_byte          (i_in.data_byte),
        .i_expected_rate (r_expected_rate),
        .i_max_riff_size (r_max_riff_size),
        .o_state         (n_state),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // register writes, unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_rate <= rwpe_pkg::RESET_RATE;
            r_max_riff_size <= rwpe_pkg::RESET_MAX_SIZE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rwpe_pkg::CFG_EXPECTED_RATE: r_expected_rate <= i_cfg.data;
                rwpe_pkg::CFG_MAX_RIFF_SIZE: r_max_riff_size <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // parser state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: rwpe_pkg::PH_RIFF, default: '0};
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // output register: load a new result or empty when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample     = r_out.sample;
    assign o_out.kind       = r_out.kind;
    assign o_out.error_code = r_out.error_code;
    assign o_out.last       = r_out.last;

    // an error result on the output always leaves the parser halted
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == rwpe_pkg::KIND_ERROR
        |-> r_state.phase == rwpe_pkg::PH_HALT)
        else $error("error result without halted parser");

    // once done or halted, further bytes change nothing
    a_terminal_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (r_state.phase == rwpe_pkg::PH_DONE
                   || r_state.phase == rwpe_pkg::PH_HALT)
        |=> r_state == $past(r_state))
        else $error("parser state moved after end of stream");

    // skip and data phases always have bytes still to consume
    a_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == rwpe_pkg::PH_SKIP || r_state.phase == rwpe_pkg::PH_DATA
        |-> r_state.bytes_left != 32'd0)
        else $error("chunk body phase with no bytes left");

    // a sample result carries no error code
    a_sample_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && res_valid && res.kind == rwpe_pkg::KIND_SAMPLE
        |=> r_out.error_code == rwpe_pkg::ERR_NONE
            && $past(r_state.phase) == rwpe_pkg::PH_DATA)
        else $error("sample result outside data chunk");

endmodule

// File: src/rwpe_step.sv
// ----------------------------------------------------------------------------
// rwpe_step
// one byte of the chunk walk: next parser state and the result it causes
// ----------------------------------------------------------------------------
module rwpe_step (
    input  rwpe_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_expected_rate,
    input  logic [31:0]       i_max_riff_size,
    output rwpe_pkg::t_state  o_state,
    output logic              o_res_valid,
    output rwpe_pkg::t_result o_res
);

    rwpe_pkg::t_state s;
    logic [31:0]      bl_dec;

    assign bl_dec = i_state.bytes_left - 32'd1;

    always_comb begin
        s           = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (i_state.phase)
            rwpe_pkg::PH_RIFF: begin
                if (i_state.position < 4'd4) begin
                    s.chunk_id_word = {i_byte, i_state.chunk_id_word[31:8]};
                end else if (i_state.position < 4'd8) begin
                    s.chunk_size_word = {i_byte, i_state.chunk_size_word[31:8]};
                end
                if (i_state.position == 4'd3 && s.chunk_id_word != rwpe_pkg::ID_RIFF) begin
                    s.phase          = rwpe_pkg::PH_HALT;
                    o_res_valid      = 1'b1;
                    o_res.kind       = rwpe_pkg::KIND_ERROR;
                    o_res.error_code = rwpe_pkg::ERR_NOT_RIFF;
                    o_res.last       = 1'b1;
                end else if (i_state.position == 4'd7
                             && s.chunk_size_word > i_max_riff_size) begin
                    s.phase          = rwpe_pkg::PH_HALT;
                    o_res_valid      = 1'b1;
                    o_res.kind       = rwpe_pkg::KIND_ERROR;
                    o_res.error_code = rwpe_pkg::ERR_TOO_BIG;
                    o_res.last       = 1'b1;
                end else if (i_state.position == 4'd11) begin
                    s.position = 4'd0;
                    s.phase    = rwpe_pkg::PH_HEAD;
                end else begin
                    s.position = i_state.position + 4'd1;
                end
            end

            rwpe_pkg::PH_HEAD: begin
                if (i_state.position < 4'd4) begin
                    s.chunk_id_word = {i_byte, i_state.chunk_id_word[31:8]};
                end else begin
                    s.chunk_size_word = {i_byte, i_state.chunk_size_word[31:8]};
                end
                if (i_state.position < 4'd7) begin
                    s.position = i_state.position + 4'd1;
                end else begin
                    s.position   = 4'd0;
                    s.bytes_left = s.chunk_size_word;
                    if (!i_state.fmt_seen && s.chunk_id_word == rwpe_pkg::ID_FMT) begin
                        if (s.chunk_size_word < rwpe_pkg::FMT_MIN_SIZE) begin
                            s.phase          = rwpe_pkg::PH_HALT;
                            o_res_valid      = 1'b1;
                            o_res.kind       = rwpe_pkg::KIND_ERROR;
                            o_res.error_code = rwpe_pkg::ERR_SHORT_FMT;
                            o_res.last       = 1'b1;
                        end else begin
                            s.phase = rwpe_pkg::PH_FMT;
                        end
                    end else if (i_state.fmt_seen && s.chunk_id_word == rwpe_pkg::ID_DATA) begin
                        s.phase = (s.chunk_size_word == 32'd0) ? rwpe_pkg::PH_DONE
                                                               : rwpe_pkg::PH_DATA;
                    end else begin
                        s.phase = (s.chunk_size_word == 32'd0) ? rwpe_pkg::PH_HEAD
                                                               : rwpe_pkg::PH_SKIP;
                    end
                end
            end

            rwpe_pkg::PH_FMT: begin
                s.bytes_left = bl_dec;
                if (i_state.position < 4'd2) begin
                    s.format_word = {i_byte, i_state.format_word[15:8]};
                end else if (i_state.position < 4'd4) begin
                    s.channels_word = {i_byte, i_state.channels_word[15:8]};
                end else if (i_state.position < 4'd8) begin
                    s.rate_word = {i_byte, i_state.rate_word[31:8]};
                end else if (i_state.position >= 4'd14) begin
                    s.bits_word = {i_byte, i_state.bits_word[15:8]};
                end
                if (i_state.position < 4'd15) begin
                    s.position = i_state.position + 4'd1;
                end else begin
                    s.position = 4'd0;
                    // checks rate, channels, bits, then format; first failure wins
                    if (s.rate_word != i_expected_rate) begin
                        o_res.error_code = rwpe_pkg::ERR_RATE;
                    end else if (s.channels_word != rwpe_pkg::NEED_CHANNELS) begin
                        o_res.error_code = rwpe_pkg::ERR_CHANNELS;
                    end else if (s.bits_word != rwpe_pkg::NEED_BITS) begin
                        o_res.error_code = rwpe_pkg::ERR_BITS;
                    end else if (s.format_word != rwpe_pkg::FORMAT_PCM) begin
                        o_res.error_code = rwpe_pkg::ERR_COMPRESSED;
                    end
                    if (o_res.error_code != rwpe_pkg::ERR_NONE) begin
                        s.phase     = rwpe_pkg::PH_HALT;
                        o_res_valid = 1'b1;
                        o_res.kind  = rwpe_pkg::KIND_ERROR;
                        o_res.last  = 1'b1;
                    end else begin
                        s.fmt_seen = 1'b1;
                        s.phase    = (bl_dec == 32'd0) ? rwpe_pkg::PH_HEAD
                                                       : rwpe_pkg::PH_SKIP;
                    end
                end
            end

            rwpe_pkg::PH_SKIP: begin
                s.bytes_left = bl_dec;
                if (bl_dec == 32'd0) begin
                    s.phase    = rwpe_pkg::PH_HEAD;
                    s.position = 4'd0;
                end
            end

            rwpe_pkg::PH_DATA: begin
                s.bytes_left = bl_dec;
                if (i_state.position == 4'd0) begin
                    s.low_byte = i_byte;
                    s.position = 4'd1;
                end else begin
                    s.position   = 4'd0;
                    o_res_valid  = 1'b1;
                    o_res.sample = {i_byte, i_state.low_byte};
                    o_res.kind   = rwpe_pkg::KIND_SAMPLE;
                    o_res.last   = (bl_dec < 32'd2);
                end
                if (bl_dec == 32'd0) begin
                    s.phase = rwpe_pkg::PH_DONE;
                end
            end

            default: begin
                // done or halted: bytes are swallowed
            end
        endcase

        o_state = s;
    end

endmodule
